### rtl/multi_voice_stereo_mixer_top_assert.svh
// Assertion macros for the stereo mixer.
`ifndef MULTI_VOICE_STEREO_MIXER_TOP_ASSERT_SVH
`define MULTI_VOICE_STEREO_MIXER_TOP_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define MVSM_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("mixer check failed: label");

// Antecedent implies consequent in the next cycle.
`define MVSM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mixer check failed: label");

`endif

### rtl/mvsm_pkg.sv
// Types and constants shared by the mixer modules.
`default_nettype none
package mvsm_pkg;
    localparam logic [1:0] FUNC_MIX   = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;
    localparam logic [1:0] FUNC_STOP  = 2'd3;

    localparam logic [1:0] KIND_BACKGROUND = 2'd0;
    localparam logic [1:0] KIND_EFFECT     = 2'd1;
    localparam logic [1:0] KIND_VOICE      = 2'd2;
    // unassigned kind, plays like a voice clip
    localparam logic [1:0] KIND_SPARE      = 2'd3;

    localparam logic [1:0] REG_GAIN_BG  = 2'd0;
    localparam logic [1:0] REG_GAIN_FX  = 2'd1;
    localparam logic [1:0] REG_GAIN_MIC = 2'd2;
    // no register behind this index; writes are dropped
    localparam logic [1:0] REG_UNUSED   = 2'd3;

    localparam logic [15:0] HALF_GAIN  = 16'd16384;
    localparam logic [16:0] MAX_LENGTH = 17'd65536;

    typedef struct packed {
        logic [7:0]  tag;
        logic        stereo;
        logic [1:0]  kind;
        logic [16:0] index;
        logic [16:0] length;
        logic [15:0] start;
    } clip_ent_t;

    localparam int ENT_W = $bits(clip_ent_t);

    // Saturate a 19-bit signed value to Q1.15.
    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        logic signed [15:0] r;
        if (v > 19'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -19'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/multi_voice_stereo_mixer_top.sv
// Top level of the multi-voice stereo mixer: sequencer around one multiplier.
//
//  channel   dir  contents
//  s_axis    in   tuser = func, tdata = mic/memory/clip fields
//  m_axis    out  tdata = left, right, active clip count
//  cfg       in   gain register writes
//
// Write and start finish in idle. Stop reads and checks each clip. A frame takes the mic term, then
// per clip reads, checks, scales and adds left and right terms (one multiplier, shared for mic, left
// and right terms; dropped clips are only read and checked). A looping clip past its end wraps in S_MOD.
// Reset clears the clip count and sets the gains to 16384; memories are not cleared.
// s_tready is high only when idle; a result waits in the output register.
`default_nettype none
module multi_voice_stereo_mixer_top #(
    parameter int VOICES       = 16,
    parameter int SAMPLE_WORDS = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] mic_sample, [31:16] mem_addr, [47:32] mem_data, [63:48] clip_start,
    // [80:64] clip_length, [82:81] clip_kind, [83] clip_stereo, [91:84] tag_id
    input  wire logic [95:0] s_tdata,
    // [1:0] func
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] left_sample, [31:16] right_sample, [36:32] active_clips
    output logic [39:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_data
);
    localparam int SAW = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
    localparam int SWW = (SAW > 18) ? SAW : 18;
    localparam int TAW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW  = $clog2(VOICES + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRD  = 4'd1;
    localparam logic [3:0] S_SCHK = 4'd2;
    localparam logic [3:0] S_MIC  = 4'd3;
    localparam logic [3:0] S_MICS = 4'd4;
    localparam logic [3:0] S_TRD  = 4'd5;
    localparam logic [3:0] S_TCHK = 4'd6;
    localparam logic [3:0] S_MOD  = 4'd7;
    localparam logic [3:0] S_LMUL = 4'd8;
    localparam logic [3:0] S_LADD = 4'd9;
    localparam logic [3:0] S_RADD = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] j_reg, j_next;
    logic [15:0]   gain_bg_reg, gain_fx_reg, gain_mic_reg;
    logic [7:0]    stop_tag_reg, stop_tag_next;
    logic signed [15:0] mic_reg, mic_next;
    logic signed [15:0] left_reg, left_next, right_reg, right_next;
    logic signed [15:0] ls_reg, ls_next;
    logic signed [32:0] prod_reg, prod_next;
    mvsm_pkg::clip_ent_t ent_reg, ent_next;
    logic          m_valid_reg, m_valid_next;
    logic [39:0]   m_data_reg, m_data_next;

    logic                  s_acc;
    logic [1:0]            func;
    logic [16:0]           in_len;
    logic                  tab_we;
    logic [TAW-1:0]        tab_waddr;
    mvsm_pkg::clip_ent_t   tab_wdata, tab_rdata;
    logic [mvsm_pkg::ENT_W-1:0] tab_rbits;
    logic                  smp_we;
    logic [SAW-1:0]        smp_raddr, smp_waddr;
    logic [15:0]           smp_rdata;
    logic [17:0]           rd_sum;
    logic [SWW-1:0]        rd_wide, wr_wide;
    logic signed [15:0]    mul_a;
    logic [15:0]           mul_b;
    logic [15:0]           ent_gain;
    logic signed [17:0]    term;
    logic [CW-1:0]         k_inc;
    logic                  drop;

    assign s_acc  = s_tvalid && s_tready;
    assign func   = s_tuser;
    assign in_len = (s_tdata[80:64] > mvsm_pkg::MAX_LENGTH) ? mvsm_pkg::MAX_LENGTH
                                                            : s_tdata[80:64];
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // clip table and sample store
    mvsm_ram #(.WIDTH(mvsm_pkg::ENT_W), .DEPTH(VOICES)) u_table (
        .aclk(aclk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
        .raddr(k_reg[TAW-1:0]), .rdata(tab_rbits)
    );
    assign tab_rdata = tab_rbits;

    assign rd_sum  = {2'b0, ent_reg.start} + {1'b0, ent_reg.index}
                   + {17'b0, (state_reg == S_LMUL)};
    assign rd_wide = SWW'(rd_sum);
    assign wr_wide = SWW'(s_tdata[31:16]);
    assign smp_raddr = rd_wide[SAW-1:0];
    assign smp_waddr = wr_wide[SAW-1:0];
    assign smp_we    = s_acc && (func == mvsm_pkg::FUNC_WRITE);

    mvsm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_store (
        .aclk(aclk), .we(smp_we), .waddr(smp_waddr), .wdata(s_tdata[47:32]),
        .raddr(smp_raddr), .rdata(smp_rdata)
    );

    always_comb begin
        case (ent_reg.kind)
            mvsm_pkg::KIND_BACKGROUND: ent_gain = gain_bg_reg;
            mvsm_pkg::KIND_EFFECT:     ent_gain = gain_fx_reg;
            default:                   ent_gain = mvsm_pkg::HALF_GAIN;
        endcase
    end

    // shared multiplier operands
    always_comb begin
        case (state_reg)
            S_MIC: begin
                mul_a = mic_reg;
                mul_b = gain_mic_reg;
            end
            S_LMUL: begin
                mul_a = smp_rdata;
                mul_b = ent_gain;
            end
            default: begin
                mul_a = ent_reg.stereo ? $signed(smp_rdata) : ls_reg;
                mul_b = ent_gain;
            end
        endcase
    end

    assign term  = prod_reg[32:15];  // floor of product / 32768
    assign k_inc = k_reg + CW'(1);
    assign drop  = (tab_rdata.index >= tab_rdata.length) &&
                   (tab_rdata.kind != mvsm_pkg::KIND_BACKGROUND);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        stop_tag_next = stop_tag_reg;
        mic_next      = mic_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        ls_next       = ls_reg;
        prod_next     = $signed(mul_a) * $signed({1'b0, mul_b});
        ent_next      = ent_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        tab_we        = 1'b0;
        tab_waddr     = j_reg[TAW-1:0];
        tab_wdata     = ent_reg;

        case (state_reg)
            S_IDLE: begin
                k_next = '0;
                j_next = '0;
                if (s_acc) begin
                    case (func)
                        mvsm_pkg::FUNC_MIX: begin
                            mic_next   = s_tdata[15:0];
                            state_next = S_MIC;
                        end
                        mvsm_pkg::FUNC_START: begin
                            if (count_reg < CW'(VOICES) && in_len != 17'd0) begin
                                tab_we           = 1'b1;
                                tab_waddr        = count_reg[TAW-1:0];
                                tab_wdata.start  = s_tdata[63:48];
                                tab_wdata.length = in_len;
                                tab_wdata.index  = '0;
                                tab_wdata.kind   = s_tdata[82:81];
                                tab_wdata.stereo = s_tdata[83];
                                tab_wdata.tag    = s_tdata[91:84];
                                count_next       = count_reg + CW'(1);
                            end
                        end
                        mvsm_pkg::FUNC_STOP: begin
                            stop_tag_next = s_tdata[91:84];
                            if (count_reg != '0) begin
                                state_next = S_SRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SRD: state_next = S_SCHK;
            S_SCHK: begin
                // compact kept entries toward the front
                if (tab_rdata.tag != stop_tag_reg) begin
                    tab_we    = 1'b1;
                    tab_wdata = tab_rdata;
                    j_next    = j_reg + CW'(1);
                end
                k_next = k_inc;
                if (k_inc == count_reg) begin
                    count_next = j_next;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_SRD;
                end
            end
            S_MIC: state_next = S_MICS;
            S_MICS: begin
                left_next  = mvsm_pkg::sat16(19'(term));
                right_next = mvsm_pkg::sat16(19'(term));
                state_next = (count_reg == '0) ? S_OUT : S_TRD;
            end
            S_TRD: state_next = S_TCHK;
            S_TCHK: begin
                ent_next = tab_rdata;
                if (drop) begin
                    k_next = k_inc;
                    if (k_inc == count_reg) begin
                        count_next = j_reg;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_TRD;
                    end
                end else begin
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                // wrap a looping clip; index stays below length + 2
                if (ent_reg.index >= ent_reg.length) begin
                    ent_next.index = ent_reg.index - ent_reg.length;
                end else begin
                    state_next = S_LMUL;
                end
            end
            S_LMUL: begin
                ls_next    = smp_rdata;
                state_next = S_LADD;
            end
            S_LADD: begin
                left_next  = mvsm_pkg::sat16(19'(left_reg) + 19'(term));
                state_next = S_RADD;
            end
            S_RADD: begin
                right_next      = mvsm_pkg::sat16(19'(right_reg) + 19'(term));
                tab_we          = 1'b1;
                tab_wdata.index = ent_reg.index + (ent_reg.stereo ? 17'd2 : 17'd1);
                j_next          = j_reg + CW'(1);
                k_next          = k_inc;
                if (k_inc == count_reg) begin
                    count_next = j_next;
                    state_next = S_OUT;
                end else begin
                    state_next = S_TRD;
                end
            end
            S_OUT: begin
                if (!m_valid_reg) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b0, 5'(count_reg), right_reg, left_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            k_reg        <= '0;
            j_reg        <= '0;
            m_valid_reg  <= 1'b0;
            gain_bg_reg  <= 16'd16384;
            gain_fx_reg  <= 16'd16384;
            gain_mic_reg <= 16'd16384;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            j_reg       <= j_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    mvsm_pkg::REG_GAIN_BG:  gain_bg_reg  <= cfg_data;
                    mvsm_pkg::REG_GAIN_FX:  gain_fx_reg  <= cfg_data;
                    mvsm_pkg::REG_GAIN_MIC: gain_mic_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        stop_tag_reg <= stop_tag_next;
        mic_reg      <= mic_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        ls_reg       <= ls_next;
        prod_reg     <= prod_next;
        ent_reg      <= ent_next;
        m_data_reg   <= m_data_next;
    end

`include "multi_voice_stereo_mixer_top_assert.svh"

    `MVSM_ASSERT_ALWAYS(a_count_max, aclk, aresetn, count_reg <= CW'(VOICES))
    `MVSM_ASSERT_ALWAYS(a_compact_order, aclk, aresetn, j_reg <= k_reg)
    `MVSM_ASSERT_NEXT(a_out_load, aclk, aresetn,
        state_reg == S_OUT && !m_valid_reg, m_tvalid && state_reg == S_IDLE)
endmodule
`default_nettype wire

### rtl/mvsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mvsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [WIDTH-1:0]      wdata,
    input  wire logic [AW-1:0]         raddr,
    output logic      [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
